// File: rtl/cfto_pkg.sv
package cfto_pkg;

    localparam int NUM_CUES_DEFAULT = 16;

    localparam int AGE_W      = 16;
    localparam int COUNT_W    = 4;
    localparam int CUE_WORD_W = 16;
    localparam int KIND_W     = 2;
    localparam int CHANNEL_W  = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [AGE_W-1:0]   AGE_MAX          = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;
    localparam logic [AGE_W-1:0]   HOLD_TIME_RESET  = AGE_W'(1000);
    localparam logic [COUNT_W-1:0] HOLD_LIMIT_RESET = COUNT_W'(3);

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRE   = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_ENABLE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT = CFG_IDX_W'(1);

endpackage

// File: rtl/cfto_item_if.sv
interface cfto_item_if;
    import cfto_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [CHANNEL_W-1:0] channel;
    logic                 enable;

    modport source (output valid, output kind, output channel, output enable, input ready);
    modport sink   (input valid, input kind, input channel, input enable, output ready);
endinterface

// File: rtl/cfto_result_if.sv
interface cfto_result_if;
    import cfto_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CUE_WORD_W-1:0] cue_word;
    logic                  status;
    logic                  output_enable_n;

    modport source (output valid, output cue_word, output status, output output_enable_n,
                    input ready);
    modport sink   (input valid, input cue_word, input status, input output_enable_n,
                    output ready);
endinterface

// File: rtl/cfto_cfg_if.sv
interface cfto_cfg_if;
    import cfto_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/cfto_age_mem.sv
module cfto_age_mem #(
    parameter int DEPTH = cfto_pkg::NUM_CUES_DEFAULT,
    parameter int AW    = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [cfto_pkg::AGE_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [cfto_pkg::AGE_W-1:0] rd_data
);
    import cfto_pkg::*;

    logic [AGE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] written_reg;
    logic [AGE_W-1:0] rd_data_reg;
    logic             rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_hit_reg  <= written_reg[rd_addr];
        end
    end

    // an entry never written reads as a saturated age
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr_en)
        begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : AGE_MAX;
endmodule

// File: rtl/cfto_age_alu.sv
module cfto_age_alu (
    input  logic [cfto_pkg::AGE_W-1:0] age,
    input  logic [cfto_pkg::AGE_W-1:0] hold_time,
    output logic [cfto_pkg::AGE_W-1:0] next_age,
    output logic                       expired
);
    import cfto_pkg::*;

    always_comb
    begin
        next_age = (age == AGE_MAX) ? age : age + AGE_W'(1);
        expired  = next_age > hold_time;
    end
endmodule

// File: rtl/cue_firing_timed_outputs_core.sv
// Cue output word with per-cue auto-off timers. Items arrive on req and each one returns
// exactly one result on rsp: the cue word (bit i drives cue i+1), a status bit set when a
// fire names a channel outside 1..NUM_CUES, and the active-low output enable level. A
// fire, enable or unused item passes through the EXEC and DONE states, its result loaded as
// it leaves DONE; a tick passes through the WALK and DONE states instead, its cue word set by a
// walk over the cue age memory in WALK, one entry per cycle through its single read and
// single write port and one shared saturating increment/compare unit. req.ready is high only
// between items; a result waiting in the output register does not hold off the next item.
// hold_time and hold_limit are written on cfg at indexes 0 and 1, which always accepts; write
// them only while no item is in flight.
module cue_firing_timed_outputs_core #(
    parameter int NUM_CUES = cfto_pkg::NUM_CUES_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    cfto_item_if.sink     req,
    cfto_result_if.source rsp,
    cfto_cfg_if.sink      cfg
);
    import cfto_pkg::*;

    localparam int AW = (NUM_CUES > 1) ? $clog2(NUM_CUES) : 1;
    localparam int CW = $clog2(NUM_CUES + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_WALK = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [CHANNEL_W-1:0]  channel_reg, channel_next;
    logic                  enable_in_reg, enable_in_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [NUM_CUES-1:0]   cue_bits_reg, cue_bits_next;
    logic [COUNT_W-1:0]    fire_count_reg, fire_count_next;
    logic                  enable_n_reg, enable_n_next;
    logic                  status_reg, status_next;
    logic [AGE_W-1:0]      hold_time_reg;
    logic [COUNT_W-1:0]    hold_limit_reg;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [CUE_WORD_W-1:0] rsp_word_reg;
    logic                  rsp_status_reg;
    logic                  rsp_oen_reg;
    logic                  load_rsp;

    logic                  ch_ok;
    logic [CHANNEL_W-1:0]  ch_m1;
    logic [AW-1:0]         fire_addr;
    logic [CW-1:0]         prev_cnt;
    logic [AW-1:0]         prev_addr;
    logic [NUM_CUES-1:0]   fire_base;
    logic [COUNT_W-1:0]    count_base;

    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [AGE_W-1:0]      mem_wr_data;
    logic                  mem_rd_en;
    logic [AGE_W-1:0]      mem_rd_data;
    logic [AGE_W-1:0]      alu_next_age;
    logic                  alu_expired;

    cfto_age_mem #(
        .DEPTH (NUM_CUES),
        .AW    (AW)
    ) u_age_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (mem_rd_data)
    );

    cfto_age_alu u_age_alu (
        .age       (mem_rd_data),
        .hold_time (hold_time_reg),
        .next_age  (alu_next_age),
        .expired   (alu_expired)
    );

    assign ch_ok     = (channel_reg != '0) && (channel_reg <= CHANNEL_W'(NUM_CUES));
    assign ch_m1     = channel_reg - CHANNEL_W'(1);
    assign fire_addr = ch_m1[AW-1:0];
    assign prev_cnt  = idx_reg - CW'(1);
    assign prev_addr = prev_cnt[AW-1:0];

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.cue_word        = rsp_word_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.output_enable_n = rsp_oen_reg;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        channel_next    = channel_reg;
        enable_in_next  = enable_in_reg;
        idx_next        = idx_reg;
        cue_bits_next   = cue_bits_reg;
        fire_count_next = fire_count_reg;
        enable_n_next   = enable_n_reg;
        status_next     = status_reg;
        load_rsp        = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = fire_addr;
        mem_wr_data     = '0;
        mem_rd_en       = 1'b0;
        fire_base       = cue_bits_reg;
        count_base      = fire_count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next      = req.kind;
                    channel_next   = req.channel;
                    enable_in_next = req.enable;
                    idx_next       = '0;
                    status_next    = 1'b0;
                    state_next     = (req.kind == KIND_TICK) ? ST_WALK : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (kind_reg)
                    KIND_FIRE:
                    begin
                        if (ch_ok)
                        begin
                            // clear everything first once the fire count passes the limit
                            if (fire_count_reg > hold_limit_reg)
                            begin
                                fire_base  = '0;
                                count_base = '0;
                            end
                            cue_bits_next   = fire_base | (NUM_CUES'(1) << fire_addr);
                            fire_count_next = (count_base == COUNT_MAX) ? count_base
                                                                        : count_base + COUNT_W'(1);
                            mem_wr_en       = 1'b1;
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    KIND_ENABLE:
                    begin
                        cue_bits_next = '0;
                        enable_n_next = ~enable_in_reg;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = ST_DONE;
            end
            ST_WALK:
            begin
                // read entry idx while aging and writing back entry idx-1
                mem_rd_en = (idx_reg < CW'(NUM_CUES));
                if (idx_reg != '0)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = prev_addr;
                    mem_wr_data = alu_next_age;
                    if (alu_expired)
                    begin
                        cue_bits_next = cue_bits_reg & ~(NUM_CUES'(1) << prev_addr);
                    end
                end
                idx_next = idx_reg + CW'(1);
                if (idx_reg == CW'(NUM_CUES))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    load_rsp   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cue_bits_reg   <= '0;
            fire_count_reg <= '0;
            enable_n_reg   <= 1'b1;
            hold_time_reg  <= HOLD_TIME_RESET;
            hold_limit_reg <= HOLD_LIMIT_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cue_bits_reg   <= cue_bits_next;
            fire_count_reg <= fire_count_next;
            enable_n_reg   <= enable_n_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg.valid && (cfg.index == CFG_HOLD_TIME))
            begin
                hold_time_reg <= cfg.data[AGE_W-1:0];
            end
            if (cfg.valid && (cfg.index == CFG_HOLD_LIMIT))
            begin
                hold_limit_reg <= cfg.data[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        channel_reg   <= channel_next;
        enable_in_reg <= enable_in_next;
        idx_reg       <= idx_next;
        status_reg    <= status_next;
        if (load_rsp)
        begin
            rsp_word_reg   <= CUE_WORD_W'(cue_bits_reg);
            rsp_status_reg <= status_reg;
            rsp_oen_reg    <= enable_n_reg;
        end
    end
endmodule

// File: dv/cue_firing_timed_outputs_core_tb.sv
module cue_firing_timed_outputs_core_tb;
    import cfto_pkg::*;

    localparam int NUM_CUES     = NUM_CUES_DEFAULT;
    localparam int CHOKE_CYCLES = 300;
    localparam int PHASES       = 7;

    typedef struct packed {
        logic [CUE_WORD_W-1:0] cue_word;
        logic                  status;
        logic                  output_enable_n;
    } cue_result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } row_op_t;

    typedef struct packed {
        row_op_t               op;
        kind_t                 kind;
        logic [CHANNEL_W-1:0]  channel;
        logic                  enable;
        logic                  checked;
        cue_result_t           want;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
    } row_t;

    logic clk;
    logic rst_n;

    cfto_item_if   item_ch ();
    cfto_result_if result_ch ();
    cfto_cfg_if    reg_ch ();

    cue_firing_timed_outputs_core #(
        .NUM_CUES(NUM_CUES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (item_ch),
        .rsp   (result_ch),
        .cfg   (reg_ch)
    );

    // predicted block state
    logic [NUM_CUES-1:0]   lit_cues;
    logic [COUNT_W-1:0]    fires_seen;
    logic [AGE_W-1:0]      cue_ages [NUM_CUES];
    logic                  enable_line_n;
    logic [AGE_W-1:0]      hold_time_q;
    logic [COUNT_W-1:0]    hold_limit_q;

    cue_result_t pending_words [$];
    cue_result_t seen_want;
    row_t        plan [$];
    int          fault_count;
    bit          choke;
    bit          calm;

    int unsigned hold_times  [PHASES] = '{5, 0, 65534, 20, 1, 3, 12};
    int unsigned hold_limits [PHASES] = '{3, 0, 15, 7, 15, 1, 2};

    function automatic cue_result_t advance_cues(kind_t kind, logic [CHANNEL_W-1:0] channel,
                                                 logic enable);
        cue_result_t res;
        int          i;
        res.status = 1'b0;
        case (kind)
            KIND_FIRE:
            begin
                if (channel == 0 || int'(channel) > NUM_CUES)
                    res.status = 1'b1;
                else
                begin
                    if (fires_seen > hold_limit_q)
                    begin
                        lit_cues   = '0;
                        fires_seen = '0;
                    end
                    lit_cues[int'(channel) - 1] = 1'b1;
                    cue_ages[int'(channel) - 1] = '0;
                    if (fires_seen != COUNT_MAX)
                        fires_seen = fires_seen + 1'b1;
                end
            end
            KIND_TICK:
            begin
                for (i = 0; i < NUM_CUES; i++)
                begin
                    if (cue_ages[i] != AGE_MAX)
                        cue_ages[i] = cue_ages[i] + 1'b1;
                    if (cue_ages[i] > hold_time_q)
                        lit_cues[i] = 1'b0;
                end
            end
            KIND_ENABLE:
            begin
                lit_cues      = '0;
                enable_line_n = ~enable;
            end
            default:
            begin
            end
        endcase
        res.cue_word        = CUE_WORD_W'(lit_cues);
        res.output_enable_n = enable_line_n;
        return res;
    endfunction

    function automatic row_t drive_row(kind_t kind, int channel, bit enable);
        row_t r;
        r         = '0;
        r.op      = ROW_ITEM;
        r.kind    = kind;
        r.channel = CHANNEL_W'(channel);
        r.enable  = enable;
        return r;
    endfunction

    function automatic row_t check_row(kind_t kind, int channel, bit enable, int word,
                                       bit status, bit oen_n);
        row_t r;
        r                      = drive_row(kind, channel, enable);
        r.checked              = 1'b1;
        r.want.cue_word        = CUE_WORD_W'(word);
        r.want.status          = status;
        r.want.output_enable_n = oen_n;
        return r;
    endfunction

    function automatic row_t reg_row(logic [CFG_IDX_W-1:0] idx, int value);
        row_t r;
        r         = '0;
        r.op      = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = CFG_DATA_W'(value);
        return r;
    endfunction

    task automatic send_item(kind_t kind, logic [CHANNEL_W-1:0] channel, logic enable,
                             bit checked, cue_result_t want);
        int          gap;
        cue_result_t got;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.kind    <= kind;
        item_ch.channel <= channel;
        item_ch.enable  <= enable;
        do @(posedge clk); while (!item_ch.ready);
        got = advance_cues(kind, channel, enable);
        pending_words.push_back(checked ? want : got);
    endtask

    // drop valid, then hold until every result is back and the block has settled
    task automatic await_drain();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (NUM_CUES + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= value;
        do @(posedge clk); while (!reg_ch.ready);
        case (idx)
            CFG_HOLD_TIME:  hold_time_q  = value[AGE_W-1:0];
            CFG_HOLD_LIMIT: hold_limit_q = value[COUNT_W-1:0];
            default:        ;
        endcase
        @(negedge clk);
        reg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off whenever choke is raised
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (choke)
            begin
                result_ch.ready <= 1'b0;
                repeat (CHOKE_CYCLES) @(negedge clk);
                choke = 1'b0;
                result_ch.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                result_ch.ready <= 1'b1;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_words.size() == 0)
            begin
                fault_count++;
                $display("%0t: result with nothing expected: cue_word %h status %b oen_n %b",
                         $time, result_ch.cue_word, result_ch.status,
                         result_ch.output_enable_n);
            end
            else
            begin
                seen_want = pending_words.pop_front();
                if (result_ch.cue_word !== seen_want.cue_word)
                begin
                    fault_count++;
                    $display("%0t: cue_word expected %h actual %h", $time,
                             seen_want.cue_word, result_ch.cue_word);
                end
                if (result_ch.status !== seen_want.status)
                begin
                    fault_count++;
                    $display("%0t: status bit expected %b actual %b", $time,
                             seen_want.status, result_ch.status);
                end
                if (result_ch.output_enable_n !== seen_want.output_enable_n)
                begin
                    fault_count++;
                    $display("%0t: output_enable_n expected %b actual %b", $time,
                             seen_want.output_enable_n, result_ch.output_enable_n);
                end
            end
        end
    end

    initial
    begin
        int          p;
        int          r;
        int          n;
        int          k;
        int          span;
        int          counted;
        kind_t       kind;
        logic [CHANNEL_W-1:0] channel;
        cue_result_t none;

        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.kind    = KIND_FIRE;
        item_ch.channel = '0;
        item_ch.enable  = 1'b0;
        reg_ch.valid    = 1'b0;
        reg_ch.index    = '0;
        reg_ch.data     = '0;
        choke           = 1'b0;
        calm            = 1'b0;
        fault_count     = 0;
        none            = '0;

        lit_cues      = '0;
        fires_seen    = '0;
        enable_line_n = 1'b1;
        hold_time_q   = HOLD_TIME_RESET;
        hold_limit_q  = HOLD_LIMIT_RESET;
        for (p = 0; p < NUM_CUES; p++)
            cue_ages[p] = AGE_MAX;

        plan = '{
            // ages start saturated, so a tick changes nothing visible
            check_row(KIND_TICK,   0,   0, 16'h0000, 1'b0, 1'b1),
            check_row(KIND_NONE,   7,   1, 16'h0000, 1'b0, 1'b1),
            check_row(KIND_ENABLE, 0,   1, 16'h0000, 1'b0, 1'b0),
            check_row(KIND_FIRE,   1,   0, 16'h0001, 1'b0, 1'b0),
            check_row(KIND_FIRE,   16,  1, 16'h8001, 1'b0, 1'b0),
            check_row(KIND_FIRE,   0,   0, 16'h8001, 1'b1, 1'b0),
            check_row(KIND_FIRE,   17,  0, 16'h8001, 1'b1, 1'b0),
            check_row(KIND_FIRE,   255, 1, 16'h8001, 1'b1, 1'b0),
            check_row(KIND_FIRE,   128, 0, 16'h8001, 1'b1, 1'b0),
            drive_row(KIND_FIRE,   2,   0),
            drive_row(KIND_FIRE,   3,   0),
            // fifth fire is over the default limit: word clears before the new bit
            check_row(KIND_FIRE,   4,   0, 16'h0008, 1'b0, 1'b0),
            drive_row(KIND_TICK,   33,  1),
            check_row(KIND_ENABLE, 9,   0, 16'h0000, 1'b0, 1'b1),
            reg_row(CFG_HOLD_TIME,  0),
            reg_row(CFG_HOLD_LIMIT, 0),
            drive_row(KIND_FIRE,   5,   0),
            drive_row(KIND_FIRE,   6,   1),
            drive_row(KIND_FIRE,   40,  0),
            // zero hold time: every lit cue goes out on the first tick
            check_row(KIND_TICK,   0,   0, 16'h0000, 1'b0, 1'b1),
            reg_row(CFG_HOLD_TIME,  65534),
            reg_row(CFG_HOLD_LIMIT, 15),
            check_row(KIND_ENABLE, 200, 1, 16'h0000, 1'b0, 1'b0),
            drive_row(KIND_FIRE,   16,  0),
            drive_row(KIND_NONE,   255, 0),
            drive_row(KIND_TICK,   170, 1)
        };

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].op == ROW_REG)
            begin
                await_drain();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                send_item(plan[i].kind, plan[i].channel, plan[i].enable,
                          plan[i].checked, plan[i].want);
        end

        for (p = 0; p < PHASES; p++)
        begin
            await_drain();
            write_reg(CFG_HOLD_TIME, CFG_DATA_W'(hold_times[p]));
            write_reg(CFG_HOLD_LIMIT, CFG_DATA_W'(hold_limits[p]));
            if (p == 1 || p == 4)
                choke = 1'b1;
            if (p == PHASES - 1)
                calm = 1'b1;
            span = (hold_times[p] < 22) ? int'(hold_times[p]) + 2 : 24;
            counted = 0;
            while (counted < 188)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                begin
                    // run of fires, with an odd out-of-range channel mixed in
                    n = $urandom_range(1, 6);
                    for (k = 0; k < n; k++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            channel = ($urandom_range(0, 3) == 0) ? '0 :
                                      CHANNEL_W'($urandom_range(NUM_CUES + 1, 255));
                        else
                        begin
                            channel = CHANNEL_W'($urandom_range(1, NUM_CUES));
                            counted++;
                        end
                        send_item(KIND_FIRE, channel, 1'($urandom), 1'b0, none);
                    end
                end
                else if (r < 80)
                begin
                    n = $urandom_range(1, span);
                    for (k = 0; k < n; k++)
                    begin
                        send_item(KIND_TICK, CHANNEL_W'($urandom), 1'($urandom), 1'b0, none);
                        counted++;
                    end
                end
                else if (r < 90)
                begin
                    send_item(KIND_ENABLE, CHANNEL_W'($urandom), $urandom_range(0, 3) != 0,
                              1'b0, none);
                    counted++;
                end
                else
                begin
                    kind = ($urandom_range(0, 1) == 0) ? KIND_NONE : KIND_FIRE;
                    channel = (kind == KIND_NONE) ? CHANNEL_W'($urandom) :
                              CHANNEL_W'($urandom_range(NUM_CUES + 1, 255));
                    send_item(kind, channel, 1'($urandom), 1'b0, none);
                end
            end
        end

        await_drain();
        if (fault_count == 0 && pending_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/cfto_pkg.sv
rtl/cfto_item_if.sv
rtl/cfto_result_if.sv
rtl/cfto_cfg_if.sv
rtl/cfto_age_mem.sv
rtl/cfto_age_alu.sv
rtl/cue_firing_timed_outputs_core.sv
dv/cue_firing_timed_outputs_core_tb.sv
